// ===== design/csvt_pkg.sv =====
package csvt_pkg;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_LINE_END = 1'b1;

   localparam logic KIND_CONTENT = 1'b0;
   localparam logic KIND_FIELD_END = 1'b1;

   localparam logic [1:0] CLASS_INTEGER = 2'd0;
   localparam logic [1:0] CLASS_DECIMAL = 2'd1;
   localparam logic [1:0] CLASS_TEXT = 2'd2;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [7:0] SEPARATOR_RESET = 8'd44;
   localparam int unsigned COLUMN_CAP = 255;

   typedef struct packed {
      logic chars_in_field;
      logic sign_only_so_far;
      logic digit_seen;
      logic dot_seen;
      logic not_numeric;
   } field_flags_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] content_byte;
      logic [7:0] column_index;
      logic [1:0] field_class;
      logic       line_done;
   } result_type;

endpackage

// ===== design/csvt_parser.sv =====
module csvt_parser #(
   parameter int unsigned MAX_COLUMNS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                operation,
   input  logic [7:0]          char_value,
   input  logic [7:0]          field_separator,
   output logic                has_result,
   output csvt_pkg::result_type result
);

   localparam int unsigned COL_LIMIT_INT =
      (MAX_COLUMNS - 1 > csvt_pkg::COLUMN_CAP) ? csvt_pkg::COLUMN_CAP : MAX_COLUMNS - 1;
   localparam logic [7:0] COL_LIMIT = COL_LIMIT_INT[7:0];

   logic                      inside_quotes_ff, inside_quotes_in;
   logic                      quote_pending_ff, quote_pending_in;
   csvt_pkg::field_flags_type flags_ff, flags_in;
   logic [7:0]                column_ff, column_in;

   logic is_quote;
   logic is_digit;
   logic go_outside;
   logic do_content;
   logic do_end;
   logic end_last;
   logic [1:0] end_class;

   assign is_quote = (char_value == csvt_pkg::CHAR_QUOTE);
   assign is_digit = (char_value >= csvt_pkg::CHAR_ZERO) && (char_value <= csvt_pkg::CHAR_NINE);

   always_comb begin
      inside_quotes_in = inside_quotes_ff;
      quote_pending_in = quote_pending_ff;
      flags_in = flags_ff;
      column_in = column_ff;
      go_outside = 1'b0;
      do_content = 1'b0;
      do_end = 1'b0;
      end_last = 1'b0;

      if (operation == csvt_pkg::OP_LINE_END) begin
         do_end = 1'b1;
         end_last = 1'b1;
      end else begin
         if (quote_pending_ff) begin
            quote_pending_in = 1'b0;
            if (is_quote) begin
               do_content = 1'b1;
            end else begin
               inside_quotes_in = 1'b0;
               go_outside = 1'b1;
            end
         end else if (inside_quotes_ff) begin
            if (is_quote) begin
               quote_pending_in = 1'b1;
            end else begin
               do_content = 1'b1;
            end
         end else begin
            go_outside = 1'b1;
         end
         if (go_outside) begin
            if (is_quote) begin
               inside_quotes_in = 1'b1;
            end else if (char_value == field_separator) begin
               do_end = 1'b1;
            end else begin
               do_content = 1'b1;
            end
         end
      end

      if (!flags_ff.chars_in_field || flags_ff.sign_only_so_far || flags_ff.not_numeric
          || !flags_ff.digit_seen) begin
         end_class = csvt_pkg::CLASS_TEXT;
      end else if (flags_ff.dot_seen) begin
         end_class = csvt_pkg::CLASS_DECIMAL;
      end else begin
         end_class = csvt_pkg::CLASS_INTEGER;
      end

      if (do_content) begin
         if (!flags_ff.chars_in_field) begin
            if (char_value == csvt_pkg::CHAR_PLUS || char_value == csvt_pkg::CHAR_MINUS) begin
               flags_in.sign_only_so_far = 1'b1;
            end else if (is_digit) begin
               flags_in.digit_seen = 1'b1;
            end else if (char_value == csvt_pkg::CHAR_DOT) begin
               flags_in.dot_seen = 1'b1;
            end else begin
               flags_in.not_numeric = 1'b1;
            end
         end else begin
            flags_in.sign_only_so_far = 1'b0;
            if (is_digit) begin
               flags_in.digit_seen = 1'b1;
            end else if (char_value == csvt_pkg::CHAR_DOT && !flags_ff.dot_seen) begin
               flags_in.dot_seen = 1'b1;
            end else begin
               flags_in.not_numeric = 1'b1;
            end
         end
         flags_in.chars_in_field = 1'b1;
      end

      if (do_end) begin
         flags_in = '0;
         if (end_last) begin
            column_in = '0;
            inside_quotes_in = 1'b0;
            quote_pending_in = 1'b0;
         end else if (column_ff < COL_LIMIT) begin
            column_in = column_ff + 8'd1;
         end
      end

      has_result = do_content || do_end;
      result.result_kind = do_end ? csvt_pkg::KIND_FIELD_END : csvt_pkg::KIND_CONTENT;
      result.content_byte = do_end ? 8'd0 : char_value;
      result.column_index = column_ff;
      result.field_class = do_end ? end_class : csvt_pkg::CLASS_INTEGER;
      result.line_done = end_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_quotes_ff <= 1'b0;
         quote_pending_ff <= 1'b0;
         flags_ff <= '0;
         column_ff <= '0;
      end else if (step_en) begin
         inside_quotes_ff <= inside_quotes_in;
         quote_pending_ff <= quote_pending_in;
         flags_ff <= flags_in;
         column_ff <= column_in;
      end
   end

endmodule

// ===== design/csvt_out_buf.sv =====
module csvt_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  csvt_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output csvt_pkg::result_type out_data
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   csvt_pkg::result_type main_data_ff;
   csvt_pkg::result_type skid_data_ff;
   logic                 pop;

   assign pop = main_valid_ff && !out_stall;
   assign full = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (!main_valid_ff) begin
         main_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_ff <= skid_data_ff;
         end else if (push) begin
            main_data_ff <= push_data;
         end
      end else if (!main_valid_ff) begin
         if (push) begin
            main_data_ff <= push_data;
         end
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

endmodule

// ===== design/csv_field_tokenizer_classifier_core.sv =====
// A request beat that is taken goes into the input register; its result beat is then
// held in the result register before it leaves.
// Throughput: one request beat per cycle; a two-entry result buffer takes up
// a stalled response, so the request side stalls only when both entries are full.
// Reset (synchronous, active high) clears the parser state, the column and the buffers,
// and sets the separator to a comma.
module csv_field_tokenizer_classifier_core #(
   parameter int unsigned MAX_COLUMNS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_char_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_content_byte,
   output logic [7:0] rsp_column_index,
   output logic [1:0] rsp_field_class,
   output logic       rsp_line_done,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic                 in_valid_ff;
   logic                 in_operation_ff;
   logic [7:0]           in_char_ff;
   logic [7:0]           separator_ff;
   logic                 buf_full;
   logic                 step_en;
   logic                 has_result;
   csvt_pkg::result_type step_result;
   csvt_pkg::result_type out_data;

   assign step_en = in_valid_ff && !buf_full;
   assign req_stall = in_valid_ff && buf_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         separator_ff <= csvt_pkg::SEPARATOR_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (csr_wr_en) begin
            separator_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_operation_ff <= req_operation;
         in_char_ff <= req_char_value;
      end
   end

   csvt_parser #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .operation      (in_operation_ff),
      .char_value     (in_char_ff),
      .field_separator(separator_ff),
      .has_result     (has_result),
      .result         (step_result)
   );

   csvt_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (step_en && has_result),
      .push_data(step_result),
      .full     (buf_full),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (out_data)
   );

   assign rsp_result_kind = out_data.result_kind;
   assign rsp_content_byte = out_data.content_byte;
   assign rsp_column_index = out_data.column_index;
   assign rsp_field_class = out_data.field_class;
   assign rsp_line_done = out_data.line_done;

endmodule
